[rtl/lac_pkg.sv]
package lac_pkg;

    // field widths
    localparam int RAD_W   = 16;
    localparam int ANGLE_W = 14;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int CIDX_W  = 2;

    // datapath widths
    localparam int PROD_W  = 36;
    localparam int FOLD_W  = 17;
    localparam int DIST_W  = 17;
    localparam int ABS_W   = 16;

    // radians Q2.13 to 1/64 degree: round(2^20 * 180 * 64 / (8192 * pi))
    localparam logic signed [19:0] DEG_MULT   = 20'sd469367;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 36'sd524288;

    // half turn in 1/64 degree units and its multiples for the fold
    localparam logic [FOLD_W-1:0] SPAN_1 = 17'd11520;
    localparam logic [FOLD_W-1:0] SPAN_2 = 17'd23040;
    localparam logic [FOLD_W-1:0] SPAN_3 = 17'd34560;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_NEAR   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_FAR    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_OFFSET = 2'd2;

    // configuration reset values (80, 170 and 5 degrees)
    localparam logic [ANGLE_W-1:0] NEAR_RST   = 14'd5120;
    localparam logic [ANGLE_W-1:0] FAR_RST    = 14'd10880;
    localparam logic [ANGLE_W-1:0] OFFSET_RST = 14'd320;

    typedef struct packed {
        logic [ANGLE_W-1:0] near_thr;
        logic [ANGLE_W-1:0] far_thr;
        logic [ANGLE_W-1:0] offset;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LOAD,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

[rtl/lac_if.sv]
interface lac_in_if import lac_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [RAD_W-1:0]   angle_rad;
    logic                      first_of_set;

    modport source (output valid, output angle_rad, output first_of_set, input ready);
    modport sink   (input valid, input angle_rad, input first_of_set, output ready);
endinterface

interface lac_out_if import lac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     group_index;
    logic                 new_group;
    logic                 table_full;
    logic [CNT_W-1:0]     group_count;
    logic [ANGLE_W-1:0]   angle_deg;

    modport source (output valid, output group_index, output new_group, output table_full,
                    output group_count, output angle_deg, input ready);
    modport sink   (input valid, input group_index, input new_group, input table_full,
                    input group_count, input angle_deg, output ready);
endinterface

interface lac_cfg_if import lac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CIDX_W-1:0]    index;
    logic [ANGLE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/line_angle_leader_clustering_unit.sv]
// Leader clustering of line angles.
// i_in carries one line per item: angle_rad (signed Q2.13 radians) and
// first_of_set, which clears the group table and seeds group 0. o_out returns
// one item per input: group_index, new_group, table_full, group_count and the
// folded angle_deg (1/64 degree, 0 to below 180 degrees).
// i_cfg writes near_threshold (index 0), far_threshold (1) and centre_offset
// (2); it is always ready. It is to be written only while the block is idle;
// the block itself does not enforce this. An item passes from acceptance to
// its result in the output register through the multiply and fold unit
// (product and fold registers), a read setup, one compare per centre until a
// match or the last centre in the single distance compare unit fed by the
// centre memory (separate write and registered read ports), and the load of
// the output register. i_in is ready only in the idle state, so one item is
// in work at a time. A new item is taken while the previous result still waits
// in the output register; if the receiver stalls, the next result waits in the
// sequencer until the register frees. Reset empties the table, restores the
// register defaults and drops any pending result; no clearing pass is needed.
module line_angle_leader_clustering_unit import lac_pkg::*; #(
    parameter int MAX_GROUPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lac_in_if.sink        i_in,
    lac_out_if.source     o_out,
    lac_cfg_if.sink       i_cfg
);

    localparam int IW = $clog2(MAX_GROUPS);
    localparam int CW = $clog2(MAX_GROUPS + 1);

    t_state             r_state;
    t_state             n_state;
    t_cfg               r_cfg;
    logic               r_first;
    logic [ANGLE_W-1:0] r_angle;
    logic [CW-1:0]      r_held;
    logic [CW-1:0]      n_held;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      n_idx;
    logic [IW-1:0]      r_res_idx;
    logic [IW-1:0]      n_res_idx;
    logic               r_fresh;
    logic               n_fresh;
    logic               r_full;
    logic               n_full;

    logic               r_out_vld;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_new;
    logic               r_out_full;
    logic [CW-1:0]      r_out_cnt;
    logic [ANGLE_W-1:0] r_out_angle;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_fold_done;
    logic [ANGLE_W-1:0] w_fold_angle;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [ANGLE_W-1:0] w_wdata;
    logic [IW-1:0]      w_raddr;
    logic [ANGLE_W-1:0] w_rdata;
    logic               w_match;
    logic               w_last;
    logic               w_room;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_last     = (CW'(r_idx) + CW'(1)) == r_held;
    assign w_room     = r_held < CW'(MAX_GROUPS);

    // angle conversion unit
    lac_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc),
        .i_angle_rad (i_in.angle_rad),
        .o_done      (w_fold_done),
        .o_angle_deg (w_fold_angle)
    );

    // centre memory
    lac_store #(
        .DEPTH (MAX_GROUPS),
        .AW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared distance compare unit
    lac_match u_match (
        .i_cfg    (r_cfg),
        .i_centre (w_rdata),
        .i_angle  (r_angle),
        .o_match  (w_match)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_fold_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_held == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match || w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath control per state
    always_comb begin
        n_held    = r_held;
        n_idx     = r_idx;
        n_res_idx = r_res_idx;
        n_fresh   = r_fresh;
        n_full    = r_full;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = r_angle;
        w_raddr   = '0;
        case (r_state)
            S_CONV: begin
                // first of set seeds group 0
                w_wdata = w_fold_angle;
                if (w_fold_done && r_first) begin
                    w_we   = 1'b1;
                    n_held = CW'(1);
                end
            end
            S_LOAD: begin
                n_idx = '0;
                if (r_held == '0) begin
                    // empty table: found group 0
                    w_we      = 1'b1;
                    n_held    = CW'(1);
                    n_res_idx = '0;
                    n_fresh   = 1'b1;
                    n_full    = 1'b0;
                end
            end
            S_SCAN: begin
                w_raddr = r_idx + IW'(1);
                if (w_match) begin
                    n_res_idx = r_idx;
                    n_fresh   = r_first && (r_idx == '0);
                    n_full    = 1'b0;
                end else if (w_last) begin
                    if (w_room) begin
                        // append a new centre
                        w_we      = 1'b1;
                        w_waddr   = r_held[IW-1:0];
                        n_held    = r_held + CW'(1);
                        n_res_idx = r_held[IW-1:0];
                        n_fresh   = 1'b1;
                        n_full    = 1'b0;
                    end else begin
                        n_res_idx = '0;
                        n_fresh   = 1'b0;
                        n_full    = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
        end
    end

    // item working registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_res_idx <= n_res_idx;
        r_fresh   <= n_fresh;
        r_full    <= n_full;
        if (w_in_acc) begin
            r_first <= i_in.first_of_set;
        end
        if (r_state == S_CONV && w_fold_done) begin
            r_angle <= w_fold_angle;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_thr <= NEAR_RST;
            r_cfg.far_thr  <= FAR_RST;
            r_cfg.offset   <= OFFSET_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_NEAR:   r_cfg.near_thr <= i_cfg.data;
                REG_FAR:    r_cfg.far_thr  <= i_cfg.data;
                REG_OFFSET: r_cfg.offset   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_idx   <= IDX_W'(r_res_idx);
            r_out_new   <= r_fresh;
            r_out_full  <= r_full;
            r_out_cnt   <= r_held;
            r_out_angle <= r_angle;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_vld;
    assign o_out.group_index = r_out_idx;
    assign o_out.new_group   = r_out_new;
    assign o_out.table_full  = r_out_full;
    assign o_out.group_count = CNT_W'(r_out_cnt);
    assign o_out.angle_deg   = r_out_angle;

endmodule

[rtl/lac_fold.sv]
module lac_fold import lac_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [RAD_W-1:0]   i_angle_rad,
    output logic                      o_done,
    output logic [ANGLE_W-1:0]        o_angle_deg
);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_round;
    logic signed [RAD_W-1:0]  w_deg;
    logic [FOLD_W-1:0]        w_pos;
    logic [FOLD_W-1:0]        w_mod;
    logic [ANGLE_W-1:0]       r_angle;
    logic                     r_prod_vld;
    logic                     r_done;

    // scale radians to 1/64 degree
    assign w_prod = PROD_W'(i_angle_rad) * PROD_W'(DEG_MULT);

    // round half up, floor shift, then bias positive by two half turns
    assign w_round = r_prod + ROUND_BIAS;
    assign w_deg   = w_round[PROD_W-1:20];
    assign w_pos   = FOLD_W'(w_deg) + SPAN_2;

    // modulo one half turn, value stays below four spans
    always_comb begin
        if (w_pos < SPAN_1) begin
            w_mod = w_pos;
        end else if (w_pos < SPAN_2) begin
            w_mod = w_pos - SPAN_1;
        end else if (w_pos < SPAN_3) begin
            w_mod = w_pos - SPAN_2;
        end else begin
            w_mod = w_pos - SPAN_3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod;
        r_angle <= w_mod[ANGLE_W-1:0];
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_prod_vld <= i_start;
            r_done     <= r_prod_vld;
        end
    end

    assign o_done      = r_done;
    assign o_angle_deg = r_angle;

endmodule

[rtl/lac_match.sv]
module lac_match import lac_pkg::*; (
    input  t_cfg                 i_cfg,
    input  logic [ANGLE_W-1:0]   i_centre,
    input  logic [ANGLE_W-1:0]   i_angle,
    output logic                 o_match
);

    logic signed [DIST_W-1:0] w_d1;
    logic signed [DIST_W-1:0] w_d2;
    logic [ABS_W-1:0]         w_a1;
    logic [ABS_W-1:0]         w_a2;
    logic [ABS_W-1:0]         w_min;

    // gaps to the centre shifted up and down by the offset
    assign w_d1 = $signed(DIST_W'(i_centre)) + $signed(DIST_W'(i_cfg.offset))
                - $signed(DIST_W'(i_angle));
    assign w_d2 = $signed(DIST_W'(i_centre)) - $signed(DIST_W'(i_cfg.offset))
                - $signed(DIST_W'(i_angle));

    assign w_a1 = w_d1[DIST_W-1] ? ABS_W'(-w_d1) : ABS_W'(w_d1);
    assign w_a2 = w_d2[DIST_W-1] ? ABS_W'(-w_d2) : ABS_W'(w_d2);
    assign w_min = (w_a1 < w_a2) ? w_a1 : w_a2;

    // near match or wrap-around match
    assign o_match = (w_min <= ABS_W'(i_cfg.near_thr)) || (w_min >= ABS_W'(i_cfg.far_thr));

endmodule

[rtl/lac_store.sv]
module lac_store import lac_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [ANGLE_W-1:0]   i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [ANGLE_W-1:0]   o_rdata
);

    logic [ANGLE_W-1:0] r_mem [DEPTH];
    logic [ANGLE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
